@@ rtl/dpss_pkg.sv @@
// ---------------------------------------------------------------------------
// dpss_pkg
// Shared types and constants for the seam finder: phase and controller
// state codes, register indexes, direction codes and the control word.
// ---------------------------------------------------------------------------
package dpss_pkg;

  // default region limits
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  // configuration register indexes and reset values
  localparam logic [1:0] CFG_REGION_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_REGION_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MARGIN        = 2'd2;
  localparam logic [9:0] RST_REGION_WIDTH  = 10'd512;
  localparam logic [9:0] RST_REGION_HEIGHT = 10'd512;
  localparam logic [8:0] RST_MARGIN        = 9'd0;

  // input opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_TRACE = 1'b1;

  // direction codes
  localparam logic [1:0] DIR_LEFT   = 2'd0;
  localparam logic [1:0] DIR_CENTRE = 2'd1;
  localparam logic [1:0] DIR_RIGHT  = 2'd2;

  // Q.4 form of 255
  localparam int SCORE_FULL = 4080;

  // sequencing lengths
  localparam int SSD_STEPS    = 3;   // one channel per cycle
  localparam int SQRT_STEPS   = 14;  // one result bit per cycle
  localparam int SQRT_TOP_EXP = 26;  // highest power of four tried
  localparam int READ_STEPS   = 4;   // three reads plus registered data

  typedef enum logic [1:0] {
    PH_LOADING,
    PH_READY,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SSD,
    ST_SQRT,
    ST_READ,
    ST_COMMIT,
    ST_TRACE_RD,
    ST_TRACE_UPD
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic       accept_pix;
    logic       accept_trace;
    logic       ssd_en;
    logic       sqrt_en;
    logic       rd_en;
    logic       commit;
    logic       trace_rd;
    logic       trace_upd;
    logic [3:0] step;
  } dpss_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic trace_more;
    logic out_busy;
  } dpss_status_t;

endpackage

@@ rtl/dpss_ctrl.sv @@
// ---------------------------------------------------------------------------
// dpss_ctrl
// Sequencer for the seam finder: takes one word at a time and steps the
// datapath through squared difference, square root, neighbour reads and
// commit, or through the direction read of a trace step.
// ---------------------------------------------------------------------------
module dpss_ctrl
  import dpss_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_opcode,
  output logic         in_stall,
  input  dpss_status_t status,
  output dpss_cmd_t    cmd
);

  ctl_state_t state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic       take;

  assign take = (state_r == ST_IDLE) && in_valid && !status.out_busy;

  // state and step registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (take) begin
          if (in_opcode == OP_PIXEL) state_nxt = ST_SSD;
          else if (status.trace_more) state_nxt = ST_TRACE_RD;
        end
      end
      ST_SSD: begin
        if (step_r == 4'(SSD_STEPS - 1)) begin
          state_nxt = ST_SQRT;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      ST_SQRT: begin
        if (step_r == 4'(SQRT_STEPS - 1)) begin
          state_nxt = ST_READ;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      ST_READ: begin
        if (step_r == 4'(READ_STEPS - 1)) begin
          state_nxt = ST_COMMIT;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      ST_COMMIT:    state_nxt = ST_IDLE;
      ST_TRACE_RD:  state_nxt = ST_TRACE_UPD;
      ST_TRACE_UPD: state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd              = '0;
    cmd.step         = step_r;
    in_stall         = (state_r != ST_IDLE) || status.out_busy;
    cmd.accept_pix   = take && (in_opcode == OP_PIXEL);
    cmd.accept_trace = take && (in_opcode == OP_TRACE);
    cmd.ssd_en       = (state_r == ST_SSD);
    cmd.sqrt_en      = (state_r == ST_SQRT);
    cmd.rd_en        = (state_r == ST_READ);
    cmd.commit       = (state_r == ST_COMMIT);
    cmd.trace_rd     = (state_r == ST_TRACE_RD);
    cmd.trace_upd    = (state_r == ST_TRACE_UPD);
  end

`ifndef SYNTH
  a_pix_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept_pix |=> (state_r == ST_SSD) && (step_r == 4'd0))
    else $error("pixel word did not start the score sequence");

  a_sqrt_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQRT) && (step_r == 4'(SQRT_STEPS - 1)) |=> (state_r == ST_READ))
    else $error("square root did not hand over to the neighbour reads");

  a_trace_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept_trace && status.trace_more |=> (state_r == ST_TRACE_RD)
      ##1 (state_r == ST_TRACE_UPD))
    else $error("trace step skipped its direction read");

  a_commit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMIT) |=> (state_r == ST_IDLE))
    else $error("commit did not return to idle");
`endif

endmodule

@@ rtl/dpss_datapath.sv @@
// ---------------------------------------------------------------------------
// dpss_datapath
// Score arithmetic, ping-pong row score memory, direction memory, load and
// trace counters, configuration registers and the result register.
// ---------------------------------------------------------------------------
module dpss_datapath
  import dpss_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic         clk,
  input  logic         rst_n,
  input  dpss_cmd_t    cmd,
  output dpss_status_t status,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [9:0]   cfg_data,
  input  logic         in_mask_first,
  input  logic         in_mask_second,
  input  logic [7:0]   in_first_red,
  input  logic [7:0]   in_first_green,
  input  logic [7:0]   in_first_blue,
  input  logic [7:0]   in_second_red,
  input  logic [7:0]   in_second_green,
  input  logic [7:0]   in_second_blue,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [8:0]   out_seam_row,
  output logic [8:0]   out_seam_column,
  output logic         out_seam_valid,
  output logic         out_last
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int EWC = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (EWC > 10) ? EWC : 10;
  localparam int EHC = $clog2(MAX_HEIGHT + 1);
  localparam int EH  = (EHC > 10) ? EHC : 10;
  localparam int DDEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int DAW = $clog2(DDEPTH);
  localparam int SQW = SQRT_TOP_EXP + 1;

  // configuration
  logic [9:0] region_width_r, region_height_r;
  logic [8:0] margin_r;

  // pixel word
  logic       mask_ok_r;
  logic [7:0] fa_r [3];
  logic [7:0] fb_r [3];

  // arithmetic
  logic [17:0]    ssd_r;
  logic [SQW-1:0] v_r, res_r;
  logic signed [31:0] prev_c_r, prev_l_r, prev_r_r;

  // counters and tracking
  logic [CW-1:0] load_col_r;
  logic [RW-1:0] load_row_r;
  logic          bank_r;
  logic [CW-1:0] best_col_r;
  logic signed [31:0] best_score_r;
  logic [CW-1:0] trace_col_r;
  logic [RW-1:0] trace_row_r;
  phase_t        phase_r;

  // memories
  logic signed [31:0] row_mem [2**(CW+1)];
  logic signed [31:0] row_rdata_r;
  logic [CW:0]        row_raddr;
  logic [1:0]         dir_mem [DDEPTH];
  logic [1:0]         dir_rdata_r;

  // result register
  logic       out_valid_r;
  logic [8:0] out_row_r, out_col_r;
  logic       out_sv_r, out_last_r;

  // ---- region geometry ----
  logic [EW-1:0] eff_w, lo, hi, col_e, col_inc;
  logic [EH-1:0] eff_h, row_inc;
  logic          narrow, in_band;

  always_comb begin
    if (region_width_r == '0) eff_w = EW'(1);
    else if (EW'(region_width_r) > EW'(MAX_WIDTH)) eff_w = EW'(MAX_WIDTH);
    else eff_w = EW'(region_width_r);
    if (region_height_r == '0) eff_h = EH'(1);
    else if (EH'(region_height_r) > EH'(MAX_HEIGHT)) eff_h = EH'(MAX_HEIGHT);
    else eff_h = EH'(region_height_r);
    lo      = EW'(margin_r);
    narrow  = eff_w <= EW'({margin_r, 1'b0});
    hi      = narrow ? lo : eff_w - lo;
    col_e   = EW'(load_col_r);
    col_inc = col_e + EW'(1);
    row_inc = EH'(load_row_r) + EH'(1);
    in_band = (col_e >= lo) && (col_e < hi);
  end

  // ---- squared difference, one channel a step ----
  logic signed [8:0]  diff;
  logic signed [17:0] diff_sq;
  always_comb begin
    diff    = $signed({1'b0, fa_r[0]}) - $signed({1'b0, fb_r[0]});
    unique case (cmd.step)
      4'd0:    diff = $signed({1'b0, fa_r[0]}) - $signed({1'b0, fb_r[0]});
      4'd1:    diff = $signed({1'b0, fa_r[1]}) - $signed({1'b0, fb_r[1]});
      4'd2:    diff = $signed({1'b0, fa_r[2]}) - $signed({1'b0, fb_r[2]});
      default: diff = '0;
    endcase
    diff_sq = 18'(diff) * 18'(diff);
  end

  // ---- square root, one bit a step ----
  logic [SQW-1:0] v_cur, res_cur, sq_bit, trial;
  logic [4:0]     sh;
  always_comb begin
    v_cur   = (cmd.step == 4'd0) ? SQW'({ssd_r, 8'h00}) : v_r;
    res_cur = (cmd.step == 4'd0) ? '0 : res_r;
    sh      = 5'(SQRT_TOP_EXP) - {cmd.step, 1'b0};
    sq_bit  = SQW'(1) << sh;
    trial   = res_cur + sq_bit;
  end

  // ---- neighbour choice and score ----
  logic signed [31:0] pix_score, best, sum;
  logic [1:0]         dir;
  logic               best_upd;
  always_comb begin
    pix_score = mask_ok_r ? (32'(SCORE_FULL) - 32'(res_r)) : 32'sd0;
    best = prev_c_r;
    dir  = DIR_CENTRE;
    if ((col_e >= lo + EW'(1)) && (prev_l_r > best)) begin
      best = prev_l_r;
      dir  = DIR_LEFT;
    end
    if ((col_inc < hi) && (prev_r_r > best)) begin
      best = prev_r_r;
      dir  = DIR_RIGHT;
    end
    if (load_row_r == '0) begin
      sum = pix_score;
      dir = DIR_CENTRE;
    end else begin
      sum = pix_score + best;
    end
    best_upd = in_band && (row_inc == eff_h) && ((col_e == lo) || (sum > best_score_r));
  end

  // ---- row score memory read address ----
  always_comb begin
    unique case (cmd.step)
      4'd0:    row_raddr = {~bank_r, load_col_r};
      4'd1:    row_raddr = {~bank_r, load_col_r - CW'(1)};
      default: row_raddr = {~bank_r, load_col_r + CW'(1)};
    endcase
  end

  logic [DAW-1:0] load_daddr, trace_daddr;
  assign load_daddr  = DAW'(load_row_r) * DAW'(MAX_WIDTH) + DAW'(load_col_r);
  assign trace_daddr = DAW'(trace_row_r) * DAW'(MAX_WIDTH) + DAW'(trace_col_r);

  // row score memory
  always_ff @(posedge clk) begin
    if (cmd.commit && in_band) row_mem[{bank_r, load_col_r}] <= sum;
  end
  always_ff @(posedge clk) begin
    row_rdata_r <= row_mem[row_raddr];
  end

  // direction memory
  always_ff @(posedge clk) begin
    if (cmd.commit && in_band) dir_mem[load_daddr] <= dir;
  end
  always_ff @(posedge clk) begin
    if (cmd.trace_rd) dir_rdata_r <= dir_mem[trace_daddr];
  end

  // pixel capture and arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.accept_pix) begin
      mask_ok_r <= in_mask_first & in_mask_second;
      fa_r[0] <= in_first_red;
      fa_r[1] <= in_first_green;
      fa_r[2] <= in_first_blue;
      fb_r[0] <= in_second_red;
      fb_r[1] <= in_second_green;
      fb_r[2] <= in_second_blue;
    end
    if (cmd.ssd_en) begin
      if (cmd.step == 4'd0) ssd_r <= diff_sq;
      else ssd_r <= ssd_r + diff_sq;
    end
    if (cmd.sqrt_en) begin
      if (v_cur >= trial) begin
        v_r   <= v_cur - trial;
        res_r <= (res_cur >> 1) + sq_bit;
      end else begin
        v_r   <= v_cur;
        res_r <= res_cur >> 1;
      end
    end
    if (cmd.rd_en) begin
      unique case (cmd.step)
        4'd1:    prev_c_r <= row_rdata_r;
        4'd2:    prev_l_r <= row_rdata_r;
        4'd3:    prev_r_r <= row_rdata_r;
        default: ;
      endcase
    end
  end

  // control state: configuration, counters, phase, trace position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_width_r  <= RST_REGION_WIDTH;
      region_height_r <= RST_REGION_HEIGHT;
      margin_r        <= RST_MARGIN;
      load_col_r      <= '0;
      load_row_r      <= '0;
      bank_r          <= 1'b0;
      best_col_r      <= '0;
      best_score_r    <= '0;
      trace_col_r     <= '0;
      trace_row_r     <= '0;
      phase_r         <= PH_LOADING;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_REGION_WIDTH) region_width_r <= cfg_data;
        if (cfg_index == CFG_REGION_HEIGHT) region_height_r <= cfg_data;
        if (cfg_index == CFG_MARGIN) margin_r <= cfg_data[8:0];
        if (cfg_index == CFG_REGION_WIDTH || cfg_index == CFG_REGION_HEIGHT
            || cfg_index == CFG_MARGIN) begin
          load_col_r <= '0;
          load_row_r <= '0;
          phase_r    <= PH_LOADING;
        end
      end
      // pixel word: drop a finished seam, fold stray counters
      if (cmd.accept_pix) begin
        if (phase_r != PH_LOADING || col_e >= eff_w || EH'(load_row_r) >= eff_h) begin
          load_col_r <= '0;
          load_row_r <= '0;
        end
        phase_r <= PH_LOADING;
      end
      // commit: bottom tracking and counter advance
      if (cmd.commit) begin
        if (best_upd) begin
          best_score_r <= sum;
          best_col_r   <= load_col_r;
        end
        if (col_inc >= eff_w) begin
          load_col_r <= '0;
          bank_r     <= ~bank_r;
          if (row_inc >= eff_h) begin
            load_row_r  <= '0;
            phase_r     <= PH_READY;
            trace_row_r <= RW'(eff_h - EH'(1));
            trace_col_r <= best_upd ? load_col_r : best_col_r;
          end else begin
            load_row_r <= RW'(row_inc);
          end
        end else begin
          load_col_r <= CW'(col_inc);
        end
      end
      // trace word on the top row closes the seam
      if (cmd.accept_trace && phase_r == PH_READY && !narrow && trace_row_r == '0)
        phase_r <= PH_DONE;
      // trace step: follow the stored direction upwards
      if (cmd.trace_upd) begin
        if (dir_rdata_r == DIR_LEFT && trace_col_r != '0)
          trace_col_r <= trace_col_r - CW'(1);
        else if (dir_rdata_r == DIR_RIGHT && (EW'(trace_col_r) + EW'(1)) < EW'(MAX_WIDTH))
          trace_col_r <= trace_col_r + CW'(1);
        trace_row_r <= trace_row_r - RW'(1);
      end
    end
  end

  // result register
  logic res_ok;
  assign res_ok = (phase_r == PH_READY) && !narrow;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.accept_trace) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_trace) begin
      out_row_r  <= res_ok ? 9'(trace_row_r) : '0;
      out_col_r  <= res_ok ? 9'(trace_col_r) : '0;
      out_sv_r   <= res_ok;
      out_last_r <= res_ok && (trace_row_r == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_seam_row    = out_row_r;
  assign out_seam_column = out_col_r;
  assign out_seam_valid  = out_sv_r;
  assign out_last        = out_last_r;

  assign status.trace_more = res_ok && (trace_row_r != '0);
  assign status.out_busy   = out_valid_r && out_stall;

`ifndef SYNTH
  a_upd_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.trace_upd |-> (phase_r == PH_READY))
    else $error("trace step outside a ready seam");

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_sv_r)
    else $error("last flagged on an invalid seam point");

  a_done_after_top: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept_trace && status.trace_more |=> (phase_r == PH_READY))
    else $error("seam left ready phase before the top row");
`endif

endmodule

@@ rtl/dp_stitch_seam_finder.sv @@
// A pixel word runs 3 squared-difference steps, 14 square-root steps, the
// neighbour reads on the single row memory port and commit. A trace word's
// result is registered in the next cycle; a direction read and update follow
// while rows remain. Words go one at a time, none while a result is stalled.
// Reset (synchronous, rst_n low): registers to defaults, counters cleared,
// phase loading; score and direction memories are not cleared.
// ---------------------------------------------------------------------------
// dp_stitch_seam_finder
// Dynamic programming seam finder over a two-image overlap region: scores
// pixel pairs row by row and traces the best seam from bottom to top.
// ---------------------------------------------------------------------------
module dp_stitch_seam_finder
  import dpss_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_opcode,
  input  logic       in_mask_first,
  input  logic       in_mask_second,
  input  logic [7:0] in_first_red,
  input  logic [7:0] in_first_green,
  input  logic [7:0] in_first_blue,
  input  logic [7:0] in_second_red,
  input  logic [7:0] in_second_green,
  input  logic [7:0] in_second_blue,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [8:0] out_seam_row,
  output logic [8:0] out_seam_column,
  output logic       out_seam_valid,
  output logic       out_last
);

  dpss_cmd_t    cmd;
  dpss_status_t status;

  // sequencer
  dpss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_opcode(in_opcode),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and storage
  dpss_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_mask_first  (in_mask_first),
    .in_mask_second (in_mask_second),
    .in_first_red   (in_first_red),
    .in_first_green (in_first_green),
    .in_first_blue  (in_first_blue),
    .in_second_red  (in_second_red),
    .in_second_green(in_second_green),
    .in_second_blue (in_second_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_seam_row   (out_seam_row),
    .out_seam_column(out_seam_column),
    .out_seam_valid (out_seam_valid),
    .out_last       (out_last)
  );

endmodule
